FILE: hdl/ymcr_pkg.sv
// Shared types, protocol byte codes and the CRC-16/XMODEM byte step for the YMODEM receiver.
`default_nettype none
package ymcr_pkg;

	localparam int unsigned TOTAL_W = 25;
	localparam int unsigned WADDR_W = 24;
	localparam int unsigned SHORT_BLOCK_BYTES = 128;

	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_STX = 8'h02;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_CAN = 8'h18;
	localparam logic [7:0] B_C   = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [1:0] {
		MODE_BYTE,
		MODE_TIMEOUT,
		MODE_START,
		MODE_RESTART
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TX,
		KIND_PAYLOAD,
		KIND_NAME,
		KIND_DONE
	} kind_t;

	typedef enum logic [1:0] {
		ST_COMPLETED,
		ST_CANCELLED,
		ST_TOO_MANY_ERRORS
	} status_t;

	typedef enum logic [0:0] {
		REG_CAPACITY,
		REG_ERROR_LIMIT
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_HEAD,
		PH_SEQ,
		PH_CMP,
		PH_DATA,
		PH_CRCH,
		PH_CRCL,
		PH_CAN
	} phase_t;

	typedef enum logic [1:0] {
		NP_NAME,
		NP_SIZE,
		NP_DONE,
		NP_EMPTY
	} name_phase_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           tx_byte;
		logic [WADDR_W-1:0]   write_addr;
		logic [7:0]           write_byte;
		logic [TOTAL_W-1:0]   total_bytes;
		status_t              status;
		logic                 last;
	} res_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] tx, logic [WADDR_W-1:0] a,
		logic [7:0] wb, status_t st);
		res_t r;
		r = '0;
		r.kind = k;
		r.tx_byte = tx;
		r.write_addr = a;
		r.write_byte = wb;
		r.status = st;
		return r;
	endfunction

	// One byte through CRC-16/XMODEM, MSB first.
	function automatic logic [15:0] crc_step(logic [15:0] c_in, logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/ymcr_if.sv
// Request, result and register-write channel interfaces of the YMODEM receiver.
`default_nettype none
interface ymcr_item_if;
	logic                valid;
	logic                ready;
	ymcr_pkg::mode_t     mode;
	logic [7:0]          rx_byte;
	modport source (output valid, mode, rx_byte, input ready);
	modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface ymcr_result_if;
	logic                              valid;
	logic                              ready;
	ymcr_pkg::kind_t                   kind;
	logic [7:0]                        tx_byte;
	logic [ymcr_pkg::WADDR_W-1:0]      write_addr;
	logic [7:0]                        write_byte;
	logic [ymcr_pkg::TOTAL_W-1:0]      total_bytes;
	ymcr_pkg::status_t                 status;
	logic                              last;
	modport source (output valid, kind, tx_byte, write_addr, write_byte, total_bytes, status,
		last, input ready);
	modport sink (input valid, kind, tx_byte, write_addr, write_byte, total_bytes, status,
		last, output ready);
endinterface

interface ymcr_cfg_if;
	logic                              valid;
	logic                              ready;
	ymcr_pkg::reg_index_t              index;
	logic [ymcr_pkg::TOTAL_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/ymodem_crc_receiver.sv
// YMODEM-CRC receiver: deframing, CRC check, block-0 parsing, response and write generation.
//
// Each request is a received byte, a timeout tick or a session start. A request is registered,
// processed by combinational logic (deframing, CRC-16/XMODEM byte step, sequence checks, name and
// size parsing, truncation) and its zero to two results are loaded into a three-slot result
// register that drains one result per cycle while result.ready is high, the last flagged by last.
// A new request is taken every cycle while result.ready is high and each request yields at most
// one result; a request with more results holds the next one until its earlier ones are taken.
// The user must write the registers only while the block is idle; the block does not enforce it.
`default_nettype none
module ymodem_crc_receiver #(
	parameter int unsigned LONG_BLOCK_BYTES = 1024,
	parameter int unsigned NAME_CHARS = 63,
	parameter int unsigned ADDR_WIDTH = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	ymcr_item_if.sink          item,
	ymcr_result_if.source      result,
	ymcr_cfg_if.sink           cfg
);

	localparam int unsigned TW = ymcr_pkg::TOTAL_W;
	localparam int unsigned AW = ymcr_pkg::WADDR_W;
	localparam logic [10:0] LONG_LEN = 11'(LONG_BLOCK_BYTES);
	localparam logic [10:0] SHORT_LEN = 11'(ymcr_pkg::SHORT_BLOCK_BYTES);
	localparam logic [10:0] NAME_LIM = 11'(NAME_CHARS);
	localparam logic [AW-1:0] ADDR_MASK = (ADDR_WIDTH >= AW) ? {AW{1'b1}} :
		AW'((64'd1 << ADDR_WIDTH) - 64'd1);

	// configuration
	logic [TW-1:0]  capacity_q;
	logic [7:0]     err_limit_q;

	// input stage
	logic              valid_s1;
	ymcr_pkg::mode_t   mode_s1;
	logic [7:0]        byte_s1;

	// session state
	ymcr_pkg::phase_t       phase_q, phase_d;
	logic                   long_q, long_d;
	logic [10:0]            idx_q, idx_d;
	logic [7:0]             seq_q, seq_d;
	logic [7:0]             cmp_q, cmp_d;
	logic [15:0]            crc_q, crc_d;
	logic [7:0]             crch_q, crch_d;
	logic [7:0]             blk_q, blk_d;
	logic                   hdr_q, hdr_d;
	logic [7:0]             err_q, err_d;
	logic [TW-1:0]          total_q, total_d;
	logic [31:0]            fbytes_q, fbytes_d;
	logic [31:0]            dsize_q, dsize_d;
	ymcr_pkg::name_phase_t  np_q, np_d;
	logic                   idle_q, idle_d;

	// result register
	ymcr_pkg::res_t  slot_q [3];
	logic [1:0]      cnt_q;
	ymcr_pkg::res_t  res_d [3];
	logic [1:0]      nres;

	logic pop;
	logic adv;

	assign pop = result.valid && result.ready;
	assign adv = valid_s1 && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop));
	assign item.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	assign result.valid = cnt_q != 2'd0;
	assign result.kind = slot_q[0].kind;
	assign result.tx_byte = slot_q[0].tx_byte;
	assign result.write_addr = slot_q[0].write_addr;
	assign result.write_byte = slot_q[0].write_byte;
	assign result.total_bytes = slot_q[0].total_bytes;
	assign result.status = slot_q[0].status;
	assign result.last = slot_q[0].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= TW'(65536);
			err_limit_q <= 8'd10;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ymcr_pkg::REG_CAPACITY:    capacity_q <= cfg.data;
				ymcr_pkg::REG_ERROR_LIMIT: err_limit_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mode_s1 <= item.mode;
			byte_s1 <= item.rx_byte;
		end
	end

	always_comb begin
		logic        fail_req;
		logic        seq_ok;
		logic        expected;
		logic        crc_ok;
		logic [7:0]  err_inc;
		logic [10:0] len;
		logic [10:0] take;
		logic [10:0] idx_inc;
		logic [32:0] fsum;
		logic [25:0] csum;
		logic [25:0] addr_sum;
		logic [35:0] dprod;

		phase_d = phase_q;
		long_d = long_q;
		idx_d = idx_q;
		seq_d = seq_q;
		cmp_d = cmp_q;
		crc_d = crc_q;
		crch_d = crch_q;
		blk_d = blk_q;
		hdr_d = hdr_q;
		err_d = err_q;
		total_d = total_q;
		fbytes_d = fbytes_q;
		dsize_d = dsize_q;
		np_d = np_q;
		idle_d = idle_q;
		nres = 2'd0;
		for (int i = 0; i < 3; i++)
			res_d[i] = '0;
		fail_req = 1'b0;

		len = long_q ? LONG_LEN : SHORT_LEN;
		seq_ok = seq_q == ~cmp_q;
		expected = seq_ok && seq_q == blk_q;
		crc_ok = {crch_q, byte_s1} == crc_q;
		err_inc = (err_q == 8'hFF) ? err_q : err_q + 8'd1;
		idx_inc = idx_q + 11'd1;
		fsum = {1'b0, fbytes_q} + 33'(len);
		take = len;
		if (dsize_q != 32'd0 && fsum > {1'b0, dsize_q})
			take = (dsize_q > fbytes_q) ? 11'(dsize_q - fbytes_q) : 11'd0;
		csum = {1'b0, total_q} + 26'(take);
		addr_sum = {1'b0, total_q} + 26'(idx_q);
		dprod = {1'b0, dsize_q, 3'b000} + {3'b000, dsize_q, 1'b0} + 36'(byte_s1[3:0]);

		if (mode_s1 == ymcr_pkg::MODE_START || mode_s1 == ymcr_pkg::MODE_RESTART) begin
			total_d = '0;
			fbytes_d = '0;
			dsize_d = '0;
			np_d = ymcr_pkg::NP_NAME;
			crc_d = '0;
			crch_d = '0;
			idx_d = '0;
			idle_d = 1'b0;
			err_d = '0;
			blk_d = '0;
			hdr_d = 1'b0;
			phase_d = ymcr_pkg::PH_HEAD;
			res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_TX, ymcr_pkg::B_C, '0, '0,
				ymcr_pkg::ST_COMPLETED);
			nres = nres + 2'd1;
		end else if (!idle_q) begin
			if (mode_s1 == ymcr_pkg::MODE_TIMEOUT) begin
				fail_req = 1'b1;
			end else begin
				unique case (phase_q)
					ymcr_pkg::PH_HEAD: begin
						if (byte_s1 == ymcr_pkg::B_SOH || byte_s1 == ymcr_pkg::B_STX) begin
							long_d = byte_s1 == ymcr_pkg::B_STX;
							idx_d = '0;
							crc_d = '0;
							phase_d = ymcr_pkg::PH_SEQ;
							if (!hdr_q) begin
								dsize_d = '0;
								np_d = ymcr_pkg::NP_NAME;
							end
						end else if (byte_s1 == ymcr_pkg::B_EOT) begin
							res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_TX, ymcr_pkg::B_ACK,
								'0, '0, ymcr_pkg::ST_COMPLETED);
							nres = nres + 2'd1;
							res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_TX, ymcr_pkg::B_C,
								'0, '0, ymcr_pkg::ST_COMPLETED);
							nres = nres + 2'd1;
							err_d = '0;
							blk_d = '0;
							hdr_d = 1'b0;
						end else if (byte_s1 == ymcr_pkg::B_CAN) begin
							phase_d = ymcr_pkg::PH_CAN;
						end else begin
							fail_req = 1'b1;
						end
					end
					ymcr_pkg::PH_CAN: begin
						if (byte_s1 == ymcr_pkg::B_CAN) begin
							res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_DONE, '0, '0, '0,
								ymcr_pkg::ST_CANCELLED);
							nres = nres + 2'd1;
							idle_d = 1'b1;
							phase_d = ymcr_pkg::PH_HEAD;
						end else begin
							fail_req = 1'b1;
						end
					end
					ymcr_pkg::PH_SEQ: begin
						seq_d = byte_s1;
						phase_d = ymcr_pkg::PH_CMP;
					end
					ymcr_pkg::PH_CMP: begin
						cmp_d = byte_s1;
						phase_d = ymcr_pkg::PH_DATA;
					end
					ymcr_pkg::PH_DATA: begin
						crc_d = ymcr_pkg::crc_step(crc_q, byte_s1);
						if (!hdr_q) begin
							if (np_q == ymcr_pkg::NP_NAME) begin
								if (expected && idx_q < NAME_LIM) begin
									res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_NAME, '0,
										AW'(idx_q), byte_s1, ymcr_pkg::ST_COMPLETED);
									nres = nres + 2'd1;
								end
								if (byte_s1 == 8'd0)
									np_d = (idx_q == 11'd0) ? ymcr_pkg::NP_EMPTY :
										ymcr_pkg::NP_SIZE;
							end else if (np_q == ymcr_pkg::NP_SIZE) begin
								if (byte_s1 >= 8'h30 && byte_s1 <= 8'h39)
									dsize_d = (dprod[35:32] != 4'd0) ? 32'hFFFF_FFFF :
										dprod[31:0];
								else
									np_d = ymcr_pkg::NP_DONE;
							end
						end else if (expected && addr_sum < {1'b0, capacity_q}) begin
							res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_PAYLOAD, '0,
								addr_sum[AW-1:0] & ADDR_MASK, byte_s1, ymcr_pkg::ST_COMPLETED);
							nres = nres + 2'd1;
						end
						idx_d = idx_inc;
						if (idx_inc >= len)
							phase_d = ymcr_pkg::PH_CRCH;
					end
					ymcr_pkg::PH_CRCH: begin
						crch_d = byte_s1;
						phase_d = ymcr_pkg::PH_CRCL;
					end
					ymcr_pkg::PH_CRCL: begin
						phase_d = ymcr_pkg::PH_HEAD;
						if (!seq_ok || !crc_ok) begin
							fail_req = 1'b1;
						end else if (seq_q == blk_q) begin
							err_d = '0;
							res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_TX, ymcr_pkg::B_ACK,
								'0, '0, ymcr_pkg::ST_COMPLETED);
							nres = nres + 2'd1;
							if (!hdr_q) begin
								if (np_q == ymcr_pkg::NP_EMPTY) begin
									// empty name ends the batch
									res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_DONE, '0,
										'0, '0, ymcr_pkg::ST_COMPLETED);
									nres = nres + 2'd1;
									idle_d = 1'b1;
								end else begin
									res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_TX,
										ymcr_pkg::B_C, '0, '0, ymcr_pkg::ST_COMPLETED);
									nres = nres + 2'd1;
									hdr_d = 1'b1;
									fbytes_d = '0;
									blk_d = blk_q + 8'd1;
								end
							end else begin
								// commit only when the cut block fits the destination
								if (csum <= {1'b0, capacity_q}) begin
									total_d = csum[TW-1:0];
									fbytes_d = fbytes_q + 32'(take);
								end
								blk_d = blk_q + 8'd1;
							end
						end else if (seq_q == blk_q - 8'd1) begin
							res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_TX, ymcr_pkg::B_ACK,
								'0, '0, ymcr_pkg::ST_COMPLETED);
							nres = nres + 2'd1;
						end else begin
							err_d = err_inc;
							res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_TX, ymcr_pkg::B_NAK,
								'0, '0, ymcr_pkg::ST_COMPLETED);
							nres = nres + 2'd1;
						end
					end
					default: begin
						phase_d = ymcr_pkg::PH_HEAD;
					end
				endcase
			end
		end

		if (fail_req) begin
			phase_d = ymcr_pkg::PH_HEAD;
			err_d = err_inc;
			if (err_inc > err_limit_q) begin
				res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_DONE, '0, '0, '0,
					ymcr_pkg::ST_TOO_MANY_ERRORS);
				nres = nres + 2'd1;
				idle_d = 1'b1;
			end else begin
				res_d[nres] = ymcr_pkg::mk_res(ymcr_pkg::KIND_TX,
					hdr_q ? ymcr_pkg::B_NAK : ymcr_pkg::B_C, '0, '0, ymcr_pkg::ST_COMPLETED);
				nres = nres + 2'd1;
			end
		end

		for (int i = 0; i < 3; i++) begin
			res_d[i].total_bytes = total_d;
			res_d[i].last = (2'(i) + 2'd1) == nres;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ymcr_pkg::PH_HEAD;
			long_q <= 1'b0;
			idx_q <= '0;
			seq_q <= '0;
			cmp_q <= '0;
			crc_q <= '0;
			crch_q <= '0;
			blk_q <= '0;
			hdr_q <= 1'b0;
			err_q <= '0;
			total_q <= '0;
			fbytes_q <= '0;
			dsize_q <= '0;
			np_q <= ymcr_pkg::NP_NAME;
			idle_q <= 1'b1;
		end else if (adv) begin
			phase_q <= phase_d;
			long_q <= long_d;
			idx_q <= idx_d;
			seq_q <= seq_d;
			cmp_q <= cmp_d;
			crc_q <= crc_d;
			crch_q <= crch_d;
			blk_q <= blk_d;
			hdr_q <= hdr_d;
			err_q <= err_d;
			total_q <= total_d;
			fbytes_q <= fbytes_d;
			dsize_q <= dsize_d;
			np_q <= np_d;
			idle_q <= idle_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv) begin
			cnt_q <= nres;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// load a fresh set of results, or advance the queue by one
	always_ff @(posedge clk) begin
		if (adv) begin
			slot_q <= res_d;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule
`default_nettype wire

FILE: sim/ymodem_crc_receiver_tb.sv
// Self-checking testbench for the YMODEM-CRC receiver: directed sessions, then random sessions.
`default_nettype none
module ymodem_crc_receiver_tb;

	logic clk;
	logic arst_n;

	ymcr_item_if   item_ch();
	ymcr_result_if res_ch();
	ymcr_cfg_if    cfg_ch();

	ymodem_crc_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	localparam int NAME_LIMIT = 63;
	localparam int LONG_LEN = 1024;
	localparam int RANDOM_REQUESTS = 430;

	// Receiver state as predicted from the accepted requests.
	ymcr_pkg::phase_t       rx_phase;
	logic                   stx_blk;
	logic [10:0]            blk_pos;
	logic [7:0]             seq_num;
	logic [7:0]             seq_inv;
	logic [15:0]            crc_acc;
	logic [7:0]             crc_hi_rx;
	logic [7:0]             next_block;
	logic                   name_taken;
	logic [7:0]             err_cnt;
	logic [24:0]            total_committed;
	logic [31:0]            file_len;
	logic [31:0]            size_limit;
	ymcr_pkg::name_phase_t  np_phase;
	logic                   no_session;
	logic [24:0]            cap_bytes;
	logic [7:0]             err_limit;

	ymcr_pkg::res_t  batch[$];
	ymcr_pkg::res_t  awaited[$];
	ymcr_pkg::res_t  got;
	ymcr_pkg::res_t  oldest;
	logic            got_flag;
	logic [7:0]      blk_buf [0:LONG_LEN-1];
	logic            steady;
	int              mismatches;
	int              items_sent;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = acc[15] ^ b[i];
			acc = {acc[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
		end
		return acc;
	endfunction

	function automatic void reset_predictor();
		cap_bytes = 25'd65536;
		err_limit = 8'd10;
		rx_phase = ymcr_pkg::PH_HEAD;
		stx_blk = 1'b0;
		blk_pos = '0;
		seq_num = '0;
		seq_inv = '0;
		crc_acc = '0;
		crc_hi_rx = '0;
		next_block = '0;
		name_taken = 1'b0;
		err_cnt = '0;
		total_committed = '0;
		file_len = '0;
		size_limit = '0;
		np_phase = ymcr_pkg::NP_NAME;
		no_session = 1'b1;
	endfunction

	function automatic void add_result(ymcr_pkg::kind_t k, logic [7:0] tx, logic [23:0] a,
		logic [7:0] wb, ymcr_pkg::status_t st);
		ymcr_pkg::res_t r;
		r = '0;
		r.kind = k;
		r.tx_byte = tx;
		r.write_addr = a;
		r.write_byte = wb;
		r.total_bytes = total_committed;
		r.status = st;
		if (batch.size() < 3)
			batch.push_back(r);
	endfunction

	function automatic void end_session(ymcr_pkg::status_t st);
		add_result(ymcr_pkg::KIND_DONE, 8'h00, '0, 8'h00, st);
		no_session = 1'b1;
		rx_phase = ymcr_pkg::PH_HEAD;
	endfunction

	function automatic void fresh_file();
		err_cnt = '0;
		next_block = '0;
		name_taken = 1'b0;
		rx_phase = ymcr_pkg::PH_HEAD;
	endfunction

	function automatic void count_failure();
		rx_phase = ymcr_pkg::PH_HEAD;
		if (err_cnt != 8'hFF)
			err_cnt = err_cnt + 8'd1;
		if (err_cnt > err_limit)
			end_session(ymcr_pkg::ST_TOO_MANY_ERRORS);
		else
			add_result(ymcr_pkg::KIND_TX, name_taken ? ymcr_pkg::B_NAK : ymcr_pkg::B_C, '0,
				8'h00, ymcr_pkg::ST_COMPLETED);
	endfunction

	function automatic void close_block(logic crc_ok);
		longint unsigned take, fl, dl, sum;
		logic [7:0] prev_block;
		prev_block = next_block - 8'd1;
		rx_phase = ymcr_pkg::PH_HEAD;
		if (seq_num != ~seq_inv || !crc_ok) begin
			count_failure();
			return;
		end
		if (seq_num == next_block) begin
			err_cnt = '0;
			if (!name_taken) begin
				add_result(ymcr_pkg::KIND_TX, ymcr_pkg::B_ACK, '0, 8'h00,
					ymcr_pkg::ST_COMPLETED);
				if (np_phase == ymcr_pkg::NP_EMPTY) begin
					end_session(ymcr_pkg::ST_COMPLETED);
					return;
				end
				add_result(ymcr_pkg::KIND_TX, ymcr_pkg::B_C, '0, 8'h00, ymcr_pkg::ST_COMPLETED);
				name_taken = 1'b1;
				file_len = '0;
			end else begin
				// Cut the block to what is left of the declared size.
				take = stx_blk ? LONG_LEN : ymcr_pkg::SHORT_BLOCK_BYTES;
				fl = file_len;
				dl = size_limit;
				if (dl != 0 && fl + take > dl)
					take = (dl > fl) ? dl - fl : 0;
				sum = total_committed;
				sum = sum + take;
				if (sum <= cap_bytes) begin
					total_committed = sum[24:0];
					file_len = file_len + take[31:0];
				end
				add_result(ymcr_pkg::KIND_TX, ymcr_pkg::B_ACK, '0, 8'h00,
					ymcr_pkg::ST_COMPLETED);
			end
			next_block = next_block + 8'd1;
		end else if (seq_num == prev_block) begin
			add_result(ymcr_pkg::KIND_TX, ymcr_pkg::B_ACK, '0, 8'h00, ymcr_pkg::ST_COMPLETED);
		end else begin
			if (err_cnt != 8'hFF)
				err_cnt = err_cnt + 8'd1;
			add_result(ymcr_pkg::KIND_TX, ymcr_pkg::B_NAK, '0, 8'h00, ymcr_pkg::ST_COMPLETED);
		end
	endfunction

	function automatic void take_data(logic [7:0] b);
		longint unsigned addr, d;
		logic in_order;
		int len;
		len = stx_blk ? LONG_LEN : ymcr_pkg::SHORT_BLOCK_BYTES;
		crc_acc = crc16_update(crc_acc, b);
		in_order = (seq_num == ~seq_inv) && (seq_num == next_block);
		if (!name_taken) begin
			if (np_phase == ymcr_pkg::NP_NAME) begin
				if (in_order && blk_pos < NAME_LIMIT)
					add_result(ymcr_pkg::KIND_NAME, 8'h00, {13'd0, blk_pos}, b,
						ymcr_pkg::ST_COMPLETED);
				if (b == 8'h00)
					np_phase = (blk_pos == 0) ? ymcr_pkg::NP_EMPTY : ymcr_pkg::NP_SIZE;
			end else if (np_phase == ymcr_pkg::NP_SIZE) begin
				if (b >= 8'h30 && b <= 8'h39) begin
					d = size_limit;
					d = d * 10 + (b - 8'h30);
					size_limit = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
				end else begin
					np_phase = ymcr_pkg::NP_DONE;
				end
			end
		end else if (in_order) begin
			addr = total_committed;
			addr = addr + blk_pos;
			if (addr < cap_bytes)
				add_result(ymcr_pkg::KIND_PAYLOAD, 8'h00, addr[23:0], b,
					ymcr_pkg::ST_COMPLETED);
		end
		blk_pos = blk_pos + 11'd1;
		if (blk_pos >= len)
			rx_phase = ymcr_pkg::PH_CRCH;
	endfunction

	function automatic void take_byte(logic [7:0] b);
		case (rx_phase)
			ymcr_pkg::PH_HEAD: begin
				if (b == ymcr_pkg::B_SOH || b == ymcr_pkg::B_STX) begin
					stx_blk = (b == ymcr_pkg::B_STX);
					blk_pos = '0;
					crc_acc = '0;
					rx_phase = ymcr_pkg::PH_SEQ;
					if (!name_taken) begin
						size_limit = '0;
						np_phase = ymcr_pkg::NP_NAME;
					end
				end else if (b == ymcr_pkg::B_EOT) begin
					add_result(ymcr_pkg::KIND_TX, ymcr_pkg::B_ACK, '0, 8'h00,
						ymcr_pkg::ST_COMPLETED);
					add_result(ymcr_pkg::KIND_TX, ymcr_pkg::B_C, '0, 8'h00,
						ymcr_pkg::ST_COMPLETED);
					fresh_file();
				end else if (b == ymcr_pkg::B_CAN) begin
					rx_phase = ymcr_pkg::PH_CAN;
				end else begin
					count_failure();
				end
			end
			ymcr_pkg::PH_CAN: begin
				if (b == ymcr_pkg::B_CAN)
					end_session(ymcr_pkg::ST_CANCELLED);
				else
					count_failure();
			end
			ymcr_pkg::PH_SEQ: begin
				seq_num = b;
				rx_phase = ymcr_pkg::PH_CMP;
			end
			ymcr_pkg::PH_CMP: begin
				seq_inv = b;
				rx_phase = ymcr_pkg::PH_DATA;
			end
			ymcr_pkg::PH_DATA: take_data(b);
			ymcr_pkg::PH_CRCH: begin
				crc_hi_rx = b;
				rx_phase = ymcr_pkg::PH_CRCL;
			end
			default: close_block({crc_hi_rx, b} == crc_acc);
		endcase
	endfunction

	function automatic void predict_request(ymcr_pkg::mode_t m, logic [7:0] b);
		ymcr_pkg::res_t r;
		batch.delete();
		if (m == ymcr_pkg::MODE_START || m == ymcr_pkg::MODE_RESTART) begin
			total_committed = '0;
			file_len = '0;
			size_limit = '0;
			np_phase = ymcr_pkg::NP_NAME;
			crc_acc = '0;
			crc_hi_rx = '0;
			blk_pos = '0;
			no_session = 1'b0;
			fresh_file();
			add_result(ymcr_pkg::KIND_TX, ymcr_pkg::B_C, '0, 8'h00, ymcr_pkg::ST_COMPLETED);
		end else if (!no_session) begin
			if (m == ymcr_pkg::MODE_TIMEOUT)
				count_failure();
			else
				take_byte(b);
		end
		for (int i = 0; i < batch.size(); i++) begin
			r = batch[i];
			r.last = (i == batch.size() - 1);
			awaited.push_back(r);
		end
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
			mismatches++;
		end
	endfunction

	// Latch each accepted result at the rising edge, compare it at the falling edge that follows.
	always @(posedge clk) begin
		got_flag <= res_ch.valid && res_ch.ready;
		got <= {res_ch.kind, res_ch.tx_byte, res_ch.write_addr, res_ch.write_byte,
			res_ch.total_bytes, res_ch.status, res_ch.last};
	end

	always @(negedge clk) begin
		if (got_flag === 1'b1) begin
			if (awaited.size() == 0) begin
				$display("%0t: result with none expected: kind %0d tx %h addr %h byte %h total %0d",
					$time, got.kind, got.tx_byte, got.write_addr, got.write_byte, got.total_bytes);
				mismatches++;
			end else begin
				oldest = awaited.pop_front();
				compare_field("kind", oldest.kind, got.kind);
				compare_field("tx_byte", oldest.tx_byte, got.tx_byte);
				compare_field("write_addr", oldest.write_addr, got.write_addr);
				compare_field("write_byte", oldest.write_byte, got.write_byte);
				compare_field("total_bytes", oldest.total_bytes, got.total_bytes);
				compare_field("status", oldest.status, got.status);
				compare_field("last", oldest.last, got.last);
			end
		end
	end

	always @(negedge clk)
		res_ch.ready <= steady || ($urandom_range(99) >= 7);

	task automatic send_request(ymcr_pkg::mode_t m, logic [7:0] b);
		while (!steady && $urandom_range(99) < 7) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.mode <= m;
		item_ch.rx_byte <= b;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		predict_request(m, b);
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		// allow for requests still in flight that give no result
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(ymcr_pkg::reg_index_t idx, logic [24:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= v;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == ymcr_pkg::REG_CAPACITY)
			cap_bytes = v;
		else
			err_limit = v[7:0];
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_config(logic [24:0] cap, logic [7:0] lim);
		drain_results();
		write_reg(ymcr_pkg::REG_CAPACITY, cap);
		write_reg(ymcr_pkg::REG_ERROR_LIMIT, {17'd0, lim});
	endtask

	function automatic void fill_random();
		for (int i = 0; i < LONG_LEN; i++)
			blk_buf[i] = 8'($urandom_range(255));
	endfunction

	// Block 0: name of random nonzero bytes, its zero, the size digits, a zero, random tail.
	function automatic void load_header(int name_bytes, string size_text);
		int pos;
		fill_random();
		for (int i = 0; i < name_bytes && i < LONG_LEN; i++)
			blk_buf[i] = 8'($urandom_range(1, 255));
		pos = name_bytes;
		if (pos < LONG_LEN)
			blk_buf[pos] = 8'h00;
		pos++;
		for (int k = 0; k < size_text.len(); k++) begin
			if (pos < LONG_LEN)
				blk_buf[pos] = size_text[k];
			pos++;
		end
		if (pos < LONG_LEN)
			blk_buf[pos] = 8'h00;
	endfunction

	task automatic send_block(logic long_blk, logic [7:0] seq, logic [7:0] inv,
		logic [15:0] crc_flip);
		int len;
		logic [15:0] crc;
		len = long_blk ? LONG_LEN : ymcr_pkg::SHORT_BLOCK_BYTES;
		crc = 16'h0000;
		send_request(ymcr_pkg::MODE_BYTE, long_blk ? ymcr_pkg::B_STX : ymcr_pkg::B_SOH);
		send_request(ymcr_pkg::MODE_BYTE, seq);
		send_request(ymcr_pkg::MODE_BYTE, inv);
		for (int i = 0; i < len; i++) begin
			crc = crc16_update(crc, blk_buf[i]);
			send_request(ymcr_pkg::MODE_BYTE, blk_buf[i]);
		end
		crc = crc ^ crc_flip;
		send_request(ymcr_pkg::MODE_BYTE, crc[15:8]);
		send_request(ymcr_pkg::MODE_BYTE, crc[7:0]);
	endtask

	task automatic send_good_block(logic long_blk);
		send_block(long_blk, next_block, ~next_block, 16'h0000);
	endtask

	task automatic send_partial_block();
		send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_SOH);
		send_request(ymcr_pkg::MODE_BYTE, next_block);
		send_request(ymcr_pkg::MODE_BYTE, ~next_block);
		repeat ($urandom_range(0, 20))
			send_request(ymcr_pkg::MODE_BYTE, 8'($urandom_range(255)));
		send_request(ymcr_pkg::MODE_TIMEOUT, 8'($urandom_range(255)));
	endtask

	task automatic test_idle_requests();
		send_request(ymcr_pkg::MODE_BYTE, 8'h00);
		send_request(ymcr_pkg::MODE_BYTE, 8'hFF);
		send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_SOH);
		send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_CAN);
		send_request(ymcr_pkg::MODE_TIMEOUT, 8'hA5);
		send_request(ymcr_pkg::MODE_RESTART, 8'h5A);
		drain_results();
	endtask

	task automatic test_file_transfer();
		send_request(ymcr_pkg::MODE_START, 8'h00);
		load_header(5, "300");
		send_good_block(1'b0);
		repeat (4) begin
			fill_random();
			send_good_block(1'b0);
		end
		// resend of the last block
		send_block(1'b0, next_block - 8'd1, ~(next_block - 8'd1), 16'h0000);
		send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_EOT);
		load_header(0, "");
		send_good_block(1'b0);
		drain_results();
	endtask

	task automatic test_long_blocks();
		set_config(25'h1000000, 8'd255);
		steady <= 1'b1;
		send_request(ymcr_pkg::MODE_START, 8'h00);
		load_header(70, "");
		send_good_block(1'b1);
		fill_random();
		send_good_block(1'b1);
		fill_random();
		send_good_block(1'b0);
		// restart in the middle of a block
		send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_SOH);
		send_request(ymcr_pkg::MODE_BYTE, next_block);
		send_request(ymcr_pkg::MODE_BYTE, ~next_block);
		send_request(ymcr_pkg::MODE_BYTE, 8'h80);
		send_request(ymcr_pkg::MODE_START, 8'hFF);
		drain_results();
		steady <= 1'b0;
	endtask

	task automatic test_error_paths();
		set_config(25'd65536, 8'd3);
		send_request(ymcr_pkg::MODE_START, 8'h00);
		send_request(ymcr_pkg::MODE_TIMEOUT, 8'h00);
		send_request(ymcr_pkg::MODE_BYTE, 8'h55);
		load_header(NAME_LIMIT, "1000");
		send_good_block(1'b0);
		fill_random();
		send_block(1'b0, next_block, ~next_block, 16'h0001);
		send_block(1'b0, next_block, ~next_block ^ 8'h80, 16'h0000);
		send_block(1'b0, next_block + 8'd5, ~(next_block + 8'd5), 16'h0000);
		// lone cancel pushes the count over the limit
		send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_CAN);
		send_request(ymcr_pkg::MODE_BYTE, 8'h00);
		send_request(ymcr_pkg::MODE_START, 8'h00);
		send_partial_block();
		send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_CAN);
		send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_CAN);
		set_config(25'd65536, 8'd0);
		send_request(ymcr_pkg::MODE_START, 8'h00);
		send_request(ymcr_pkg::MODE_TIMEOUT, 8'h00);
		set_config(25'd65536, 8'd255);
		send_request(ymcr_pkg::MODE_START, 8'h00);
		// hold the count at its ceiling
		repeat (260)
			send_request(ymcr_pkg::MODE_TIMEOUT, 8'($urandom_range(255)));
		load_header(NAME_LIMIT + 1, "");
		send_good_block(1'b0);
		drain_results();
	endtask

	task automatic test_capacity_and_size();
		set_config(25'd0, 8'd10);
		send_request(ymcr_pkg::MODE_START, 8'h00);
		load_header(1, "99999999999");
		send_good_block(1'b0);
		fill_random();
		send_good_block(1'b0);
		set_config(25'd200, 8'd10);
		fill_random();
		send_good_block(1'b0);
		fill_random();
		send_good_block(1'b0);
		drain_results();
	endtask

	task automatic run_random_session();
		logic [24:0] cap;
		logic [7:0] lim;
		logic [7:0] seq;
		logic [15:0] flip;
		int pick;
		int nlen;
		string size_text;
		case ($urandom_range(4))
			0: cap = 25'd0;
			1: cap = 25'($urandom_range(1, 600));
			2: cap = 25'd65536;
			3: cap = 25'h1000000;
			default: cap = 25'($urandom_range(0, 25'h1000000));
		endcase
		case ($urandom_range(3))
			0: lim = 8'd0;
			1: lim = 8'($urandom_range(1, 4));
			2: lim = 8'd255;
			default: lim = 8'($urandom_range(255));
		endcase
		set_config(cap, lim);
		send_request($urandom_range(1) ? ymcr_pkg::MODE_START : ymcr_pkg::MODE_RESTART,
			8'($urandom_range(255)));
		repeat ($urandom_range(4, 12)) begin
			if (no_session)
				break;
			pick = int'($urandom_range(99));
			if (!name_taken) begin
				case ($urandom_range(9))
					0: nlen = 0;
					1: nlen = 70;
					default: nlen = int'($urandom_range(1, 12));
				endcase
				case ($urandom_range(5))
					0: size_text = "";
					1: size_text = "99999999999";
					default: size_text = $sformatf("%0d", $urandom_range(0, 700));
				endcase
				load_header(nlen, size_text);
				flip = 16'h0001 << $urandom_range(15);
				if (pick < 80)
					send_block(pick < 5, next_block, ~next_block, 16'h0000);
				else if (pick < 88)
					send_request(ymcr_pkg::MODE_TIMEOUT, 8'($urandom_range(255)));
				else if (pick < 94)
					send_block(1'b0, next_block, ~next_block, flip);
				else
					send_request(ymcr_pkg::MODE_BYTE, 8'($urandom_range(255)));
			end else begin
				fill_random();
				flip = 16'h0001 << $urandom_range(15);
				if (pick < 55) begin
					send_good_block($urandom_range(29) == 0);
				end else if (pick < 63) begin
					seq = next_block - 8'd1;
					send_block(1'b0, seq, ~seq, 16'h0000);
				end else if (pick < 71) begin
					case ($urandom_range(2))
						0: send_block(1'b0, next_block, ~next_block, flip);
						1: send_block(1'b0, next_block, ~next_block ^ flip[7:0] ^ flip[15:8],
							16'h0000);
						default: begin
							seq = next_block + 8'($urandom_range(2, 254));
							send_block(1'b0, seq, ~seq, 16'h0000);
						end
					endcase
				end else if (pick < 77) begin
					send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_EOT);
				end else if (pick < 83) begin
					send_partial_block();
				end else if (pick < 89) begin
					if ($urandom_range(1))
						send_request(ymcr_pkg::MODE_TIMEOUT, 8'($urandom_range(255)));
					else
						send_request(ymcr_pkg::MODE_BYTE, 8'($urandom_range(255)));
				end else if (pick < 93) begin
					send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_CAN);
					send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_CAN);
				end else if (pick < 97) begin
					send_request(ymcr_pkg::MODE_BYTE, ymcr_pkg::B_CAN);
					send_request(ymcr_pkg::MODE_BYTE, 8'($urandom_range(255)));
				end else begin
					send_request(ymcr_pkg::MODE_START, 8'($urandom_range(255)));
				end
			end
		end
	endtask

	task automatic test_random_sessions();
		int first;
		first = items_sent;
		while (items_sent - first < RANDOM_REQUESTS)
			run_random_session();
		drain_results();
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.mode = ymcr_pkg::MODE_BYTE;
		item_ch.rx_byte = 8'h00;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = ymcr_pkg::REG_CAPACITY;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		steady = 1'b0;
		mismatches = 0;
		items_sent = 0;
		reset_predictor();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_requests();
		test_file_transfer();
		test_long_blocks();
		test_error_paths();
		test_capacity_and_size();
		test_random_sessions();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
